// ----- src/cpfl_pkg.sv -----
// Package for the colored page free list: payload and job types, sizes,
// operation and status codes, and small helper functions. No dependencies.
`default_nettype none

package cpfl_pkg;

    // Sizes of the page store and of the tag hash.
    localparam int NUM_PAGES    = 1024;
    localparam int HASH_BUCKETS = 512;
    localparam int HASH_SHIFT   = 12;
    localparam int COLOR_BITS   = 4;

    localparam int PAGE_W = $clog2(NUM_PAGES);
    localparam int LINK_W = PAGE_W + 1;
    localparam int BKT_W  = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
    localparam int REF_W  = 16;
    localparam int HW_W   = 11;
    localparam int CNT_W  = 11;
    localparam int CMP_W  = (LINK_W > HW_W) ? LINK_W : HW_W;

    // Sweep length of the clearing pass after reset.
    localparam int CLR_N = (NUM_PAGES > HASH_BUCKETS) ? NUM_PAGES : HASH_BUCKETS;
    localparam int CLR_W = $clog2(CLR_N);

    localparam logic [LINK_W-1:0] NIL       = LINK_W'(NUM_PAGES);
    localparam logic [REF_W-1:0]  REF_MAX   = {REF_W{1'b1}};
    localparam logic [HW_W-1:0]   HW_RESET  = HW_W'(51);

    // Operation codes.
    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_AUX   = 3'd1;
    localparam logic [2:0] OP_REL   = 3'd2;
    localparam logic [2:0] OP_LOOK  = 3'd3;
    localparam logic [2:0] OP_INS   = 3'd4;
    localparam logic [2:0] OP_RECL  = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LOW   = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_FAULT = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [9:0]  page_index;
        logic [3:0]  color;
        logic        is_kernel_proc;
        logic [15:0] image_id;
        logic [31:0] disk_block;
        logic [10:0] reclaim_count;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  result_page;
        logic        recolored;
        logic [10:0] reclaimed;
    } t_out_item;

    // A classified request as it waits in the queue between the two halves.
    typedef struct packed {
        logic [2:0]            op;
        logic [PAGE_W-1:0]     page;
        logic                  page_ok;
        logic [COLOR_BITS-1:0] color;
        logic                  kp;
        logic [15:0]           image;
        logic [31:0]           blk;
        logic [BKT_W-1:0]      bucket;
        logic [CNT_W-1:0]      count;
    } t_job;

    // Status of the back end, for checking in the top level.
    typedef struct packed {
        logic              idle;
        logic [LINK_W-1:0] head;
        logic [LINK_W-1:0] tail;
        logic [LINK_W-1:0] free;
    } t_stat;

    function automatic logic link_ok(input logic [LINK_W-1:0] l);
        return l < NIL;
    endfunction

    function automatic logic [BKT_W-1:0] bucket_of(input logic [31:0] blk);
        return BKT_W'((blk >> HASH_SHIFT) % HASH_BUCKETS);
    endfunction

endpackage

`default_nettype wire

// ----- src/cpfl_front.sv -----
// Front end of the colored page free list: accepts requests, classifies
// them and holds them in a two-entry queue. Depends on cpfl_pkg.
`default_nettype none

module cpfl_front import cpfl_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_job_valid,
    output t_job          o_job,
    input  wire logic     i_job_pop
);

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job       w_job;
    logic       w_push;

    always_comb begin
        w_job.op      = i_in_item.op;
        w_job.page    = PAGE_W'(i_in_item.page_index);
        w_job.page_ok = LINK_W'(i_in_item.page_index) < NIL;
        w_job.color   = i_in_item.color[COLOR_BITS-1:0];
        w_job.kp      = i_in_item.is_kernel_proc;
        w_job.image   = i_in_item.image_id;
        w_job.blk     = i_in_item.disk_block;
        w_job.bucket  = bucket_of(i_in_item.disk_block);
        w_job.count   = i_in_item.reclaim_count;
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_job_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_job_pop);
        end
    end

endmodule

`default_nettype wire

// ----- src/cpfl_back.sv -----
// Back end of the colored page free list: a sequencer over the page,
// link, tag and bucket memories that carries out one request at a time.
// Depends on cpfl_pkg.
`default_nettype none

module cpfl_back import cpfl_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_job_valid,
    input  wire t_job            i_job,
    output logic                 o_job_pop,
    input  wire logic [HW_W-1:0] i_high_water,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output t_out_item            o_out_item,
    output t_stat                o_stat
);

    localparam logic [4:0] S_CLEAR   = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_START   = 5'd2;
    localparam logic [4:0] S_AL_RD   = 5'd3;
    localparam logic [4:0] S_AL_CK   = 5'd4;
    localparam logic [4:0] S_TK_RD   = 5'd5;
    localparam logic [4:0] S_TK_CK   = 5'd6;
    localparam logic [4:0] S_RL_RD   = 5'd7;
    localparam logic [4:0] S_RL_CK   = 5'd8;
    localparam logic [4:0] S_LK_B    = 5'd9;
    localparam logic [4:0] S_LK_BCK  = 5'd10;
    localparam logic [4:0] S_LK_RD   = 5'd11;
    localparam logic [4:0] S_LK_CK   = 5'd12;
    localparam logic [4:0] S_IN_RD   = 5'd13;
    localparam logic [4:0] S_IN_CK   = 5'd14;
    localparam logic [4:0] S_RC_NX   = 5'd15;
    localparam logic [4:0] S_RC_RD   = 5'd16;
    localparam logic [4:0] S_RC_CK   = 5'd17;
    localparam logic [4:0] S_UC_RD   = 5'd18;
    localparam logic [4:0] S_UC_W1   = 5'd19;
    localparam logic [4:0] S_UC_W2   = 5'd20;
    localparam logic [4:0] S_UN_RD   = 5'd21;
    localparam logic [4:0] S_UN_CK   = 5'd22;
    localparam logic [4:0] S_UN_BRD  = 5'd23;
    localparam logic [4:0] S_UN_BCK  = 5'd24;
    localparam logic [4:0] S_UN_WALK = 5'd25;
    localparam logic [4:0] S_UN_STEP = 5'd26;
    localparam logic [4:0] S_UN_CLR  = 5'd27;
    localparam logic [4:0] S_TAKE    = 5'd28;
    localparam logic [4:0] S_CH_W1   = 5'd29;
    localparam logic [4:0] S_CH_W2   = 5'd30;
    localparam logic [4:0] S_DONE    = 5'd31;

    // Memories.
    logic [LINK_W-1:0]     m_prev  [NUM_PAGES];
    logic [LINK_W-1:0]     m_next  [NUM_PAGES];
    logic [COLOR_BITS-1:0] m_color [NUM_PAGES];
    logic [REF_W-1:0]      m_ref   [NUM_PAGES];
    logic                  m_cached[NUM_PAGES];
    logic [15:0]           m_timg  [NUM_PAGES];
    logic [31:0]           m_tblk  [NUM_PAGES];
    logic [LINK_W-1:0]     m_hchain[NUM_PAGES];
    logic [LINK_W-1:0]     m_bhead [HASH_BUCKETS];

    logic [PAGE_W-1:0]     pg_ra, hc_ra;
    logic [BKT_W-1:0]      bh_ra;
    logic                  pv_we, nx_we, co_we, rc_we, ca_we, tg_we, hc_we, bh_we;
    logic [PAGE_W-1:0]     pv_wa, nx_wa, co_wa, rc_wa, ca_wa, tg_wa, hc_wa;
    logic [BKT_W-1:0]      bh_wa;
    logic [LINK_W-1:0]     pv_wd, nx_wd, hc_wd, bh_wd;
    logic [COLOR_BITS-1:0] co_wd;
    logic [REF_W-1:0]      rc_wd;
    logic                  ca_wd;
    logic [LINK_W-1:0]     pv_q, nx_q, hc_q, bh_q;
    logic [COLOR_BITS-1:0] co_q;
    logic [REF_W-1:0]      rc_q;
    logic                  ca_q;
    logic [15:0]           ti_q;
    logic [31:0]           tb_q;

    // Control registers.
    logic [4:0]        r_state, n_state;
    t_job              r_job, n_job;
    logic [LINK_W-1:0] r_p, n_p, r_before, n_before, r_cur, n_cur, r_hnext, n_hnext;
    logic [BKT_W-1:0]  r_b, n_b;
    logic [CNT_W-1:0]  r_cnt, n_cnt, r_done, n_done;
    logic              r_recol, n_recol, r_to_tail, n_to_tail;
    logic [PAGE_W-1:0] r_res, n_res;
    logic [1:0]        r_status, n_status;
    logic [LINK_W-1:0] r_head, n_head, r_tail, n_tail, r_free, n_free;
    logic [CLR_W-1:0]  r_idx;
    logic              r_out_valid;
    t_out_item         r_out;
    logic              w_low, w_match, w_out_free;
    // Predecessor in the hash chain during the unlink walk.
    logic [LINK_W-1:0] r_cur_prev;

    always_ff @(posedge i_clk) begin
        if (pv_we) m_prev[pv_wa] <= pv_wd;
        pv_q <= m_prev[pg_ra];
    end
    always_ff @(posedge i_clk) begin
        if (nx_we) m_next[nx_wa] <= nx_wd;
        nx_q <= m_next[pg_ra];
    end
    always_ff @(posedge i_clk) begin
        if (co_we) m_color[co_wa] <= co_wd;
        co_q <= m_color[pg_ra];
    end
    always_ff @(posedge i_clk) begin
        if (rc_we) m_ref[rc_wa] <= rc_wd;
        rc_q <= m_ref[pg_ra];
    end
    always_ff @(posedge i_clk) begin
        if (ca_we) m_cached[ca_wa] <= ca_wd;
        ca_q <= m_cached[pg_ra];
    end
    always_ff @(posedge i_clk) begin
        if (tg_we) m_timg[tg_wa] <= r_job.image;
        ti_q <= m_timg[pg_ra];
    end
    always_ff @(posedge i_clk) begin
        if (tg_we) m_tblk[tg_wa] <= r_job.blk;
        tb_q <= m_tblk[pg_ra];
    end
    always_ff @(posedge i_clk) begin
        if (hc_we) m_hchain[hc_wa] <= hc_wd;
        hc_q <= m_hchain[hc_ra];
    end
    always_ff @(posedge i_clk) begin
        if (bh_we) m_bhead[bh_wa] <= bh_wd;
        bh_q <= m_bhead[bh_ra];
    end

    assign w_low   = CMP_W'(r_free) <= CMP_W'(i_high_water);
    assign w_match = ca_q && (ti_q == r_job.image) && (tb_q == r_job.blk);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign pg_ra = r_p[PAGE_W-1:0];
    assign hc_ra = (r_state == S_UN_WALK) ? r_cur[PAGE_W-1:0] : r_p[PAGE_W-1:0];
    assign bh_ra = (r_state == S_UN_BRD) ? r_b : r_job.bucket;

    always_comb begin
        n_state = r_state;  n_job = r_job;     n_p = r_p;
        n_before = r_before; n_cur = r_cur;    n_hnext = r_hnext;
        n_b = r_b;          n_cnt = r_cnt;     n_done = r_done;
        n_recol = r_recol;  n_to_tail = r_to_tail;
        n_res = r_res;      n_status = r_status;
        n_head = r_head;    n_tail = r_tail;   n_free = r_free;
        o_job_pop = 1'b0;
        pv_we = 1'b0; nx_we = 1'b0; co_we = 1'b0; rc_we = 1'b0;
        ca_we = 1'b0; tg_we = 1'b0; hc_we = 1'b0; bh_we = 1'b0;
        pv_wa = r_p[PAGE_W-1:0]; nx_wa = r_p[PAGE_W-1:0];
        co_wa = r_p[PAGE_W-1:0]; rc_wa = r_p[PAGE_W-1:0];
        ca_wa = r_p[PAGE_W-1:0]; tg_wa = r_p[PAGE_W-1:0];
        hc_wa = r_p[PAGE_W-1:0]; bh_wa = r_job.bucket;
        pv_wd = NIL; nx_wd = NIL; hc_wd = NIL; bh_wd = NIL;
        co_wd = r_job.color; rc_wd = '0; ca_wd = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                // Page memories take their start values, and all buckets empty.
                pv_we = (int'(r_idx) < NUM_PAGES);
                nx_we = pv_we; co_we = pv_we; rc_we = pv_we; ca_we = pv_we;
                pv_wa = PAGE_W'(r_idx); nx_wa = PAGE_W'(r_idx); co_wa = PAGE_W'(r_idx);
                rc_wa = PAGE_W'(r_idx); ca_wa = PAGE_W'(r_idx);
                pv_wd = (r_idx == '0) ? NIL : LINK_W'(r_idx) - LINK_W'(1);
                nx_wd = (int'(r_idx) == NUM_PAGES - 1) ? NIL : LINK_W'(r_idx) + LINK_W'(1);
                co_wd = '0;
                bh_we = (int'(r_idx) < HASH_BUCKETS);
                bh_wa = BKT_W'(r_idx);
                if (int'(r_idx) == CLR_N - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_state   = S_START;
                end
            end
            S_START: begin
                n_status = ST_OK; n_res = '0; n_recol = 1'b0; n_done = '0;
                n_state  = S_DONE;
                unique case (r_job.op)
                    OP_ALLOC: begin
                        if (w_low && (!r_job.kp || r_free == '0)) begin
                            n_status = ST_LOW;
                        end else if (link_ok(r_head)) begin
                            n_p = r_head; n_state = S_AL_RD;
                        end else begin
                            n_status = ST_FAULT;
                        end
                    end
                    OP_AUX: begin
                        if (w_low) begin
                            n_status = ST_LOW;
                        end else if (link_ok(r_head)) begin
                            n_p = r_head; n_state = S_TK_RD;
                        end else begin
                            n_status = ST_FAULT;
                        end
                    end
                    OP_REL: begin
                        if (!r_job.page_ok) begin
                            n_status = ST_FAULT;
                        end else begin
                            n_p = LINK_W'(r_job.page); n_state = S_RL_RD;
                        end
                    end
                    OP_LOOK: n_state = S_LK_B;
                    OP_INS: begin
                        if (!r_job.page_ok) begin
                            n_status = ST_FAULT;
                        end else begin
                            n_p = LINK_W'(r_job.page); n_state = S_IN_RD;
                        end
                    end
                    OP_RECL: begin
                        n_p = r_tail; n_cnt = r_job.count; n_state = S_RC_NX;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_AL_RD: n_state = S_AL_CK;
            S_AL_CK: begin
                if (co_q == r_job.color) begin
                    n_state = S_TK_RD;
                end else if (link_ok(nx_q)) begin
                    n_p = nx_q; n_state = S_AL_RD;
                end else if (link_ok(r_head)) begin
                    n_p = r_head; n_recol = 1'b1; n_state = S_TK_RD;
                end else begin
                    n_status = ST_FAULT; n_state = S_DONE;
                end
            end
            S_TK_RD: n_state = S_TK_CK;
            S_TK_CK: begin
                if (rc_q == '0) begin
                    n_state = S_UC_RD;
                end else begin
                    n_status = ST_FAULT; n_recol = 1'b0; n_state = S_DONE;
                end
            end
            S_RL_RD: n_state = S_RL_CK;
            S_RL_CK: begin
                n_state = S_DONE;
                if (rc_q == '0) begin
                    n_status = ST_FAULT;
                end else begin
                    rc_we = 1'b1; rc_wd = rc_q - REF_W'(1);
                    if (rc_q == REF_W'(1)) begin
                        n_to_tail = ca_q; n_state = S_CH_W1;
                    end
                end
            end
            S_LK_B: n_state = S_LK_BCK;
            S_LK_BCK: begin
                n_p = bh_q;
                if (link_ok(bh_q)) begin
                    n_state = S_LK_RD;
                end else begin
                    n_status = ST_MISS; n_state = S_DONE;
                end
            end
            S_LK_RD: n_state = S_LK_CK;
            S_LK_CK: begin
                if (w_match) begin
                    n_state = S_DONE;
                    if (rc_q == REF_MAX) begin
                        n_status = ST_FAULT;
                    end else begin
                        rc_we = 1'b1; rc_wd = rc_q + REF_W'(1);
                        n_res = r_p[PAGE_W-1:0];
                        if (rc_q == '0) begin
                            n_state = S_UC_RD;
                        end
                    end
                end else if (link_ok(hc_q)) begin
                    n_p = hc_q; n_state = S_LK_RD;
                end else begin
                    n_status = ST_MISS; n_state = S_DONE;
                end
            end
            S_IN_RD: n_state = S_IN_CK;
            S_IN_CK: begin
                n_state = S_DONE;
                if (ca_q) begin
                    n_status = ST_FAULT;
                end else begin
                    tg_we = 1'b1;
                    ca_we = 1'b1; ca_wd = 1'b1;
                    hc_we = 1'b1; hc_wd = bh_q;
                    bh_we = 1'b1; bh_wd = r_p;
                end
            end
            S_RC_NX: begin
                if (link_ok(r_p) && r_cnt != '0) begin
                    n_state = S_RC_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RC_RD: n_state = S_RC_CK;
            S_RC_CK: begin
                if (!ca_q) begin
                    n_state = S_DONE;
                end else if (rc_q == '0) begin
                    n_before = pv_q;
                    n_cnt    = r_cnt - CNT_W'(1);
                    n_done   = r_done + CNT_W'(1);
                    n_state  = S_UC_RD;
                end else begin
                    n_p = pv_q; n_state = S_RC_NX;
                end
            end
            S_UC_RD: n_state = S_UC_W1;
            S_UC_W1: begin
                if (link_ok(pv_q)) begin
                    nx_we = 1'b1; nx_wa = pv_q[PAGE_W-1:0]; nx_wd = nx_q;
                end else begin
                    n_head = nx_q;
                end
                if (link_ok(nx_q)) begin
                    pv_we = 1'b1; pv_wa = nx_q[PAGE_W-1:0]; pv_wd = pv_q;
                end else begin
                    n_tail = pv_q;
                end
                n_state = S_UC_W2;
            end
            S_UC_W2: begin
                pv_we = 1'b1; nx_we = 1'b1;
                if (r_free != '0) begin
                    n_free = r_free - LINK_W'(1);
                end
                n_state = (r_job.op == OP_LOOK) ? S_DONE : S_UN_RD;
            end
            S_UN_RD: n_state = S_UN_CK;
            S_UN_CK: begin
                n_b     = bucket_of(tb_q);
                n_hnext = hc_q;
                n_state = ca_q ? S_UN_BRD : S_UN_CLR;
            end
            S_UN_BRD: n_state = S_UN_BCK;
            S_UN_BCK: begin
                n_cur = bh_q; n_before = NIL; n_state = S_UN_WALK;
                if (r_job.op == OP_RECL) begin
                    // Keep the saved walk link clear of the chain walk.
                    n_before = r_before;
                end
            end
            S_UN_WALK: begin
                if (!link_ok(r_cur)) begin
                    n_state = S_UN_CLR;
                end else if (r_cur == r_p) begin
                    if (link_ok(r_cur_prev)) begin
                        hc_we = 1'b1; hc_wa = r_cur_prev[PAGE_W-1:0]; hc_wd = r_hnext;
                    end else begin
                        bh_we = 1'b1; bh_wa = r_b; bh_wd = r_hnext;
                    end
                    n_state = S_UN_CLR;
                end else begin
                    n_state = S_UN_STEP;
                end
            end
            S_UN_STEP: begin
                n_cur = hc_q; n_state = S_UN_WALK;
            end
            S_UN_CLR: begin
                ca_we = 1'b1; ca_wd = 1'b0;
                if (r_job.op == OP_RECL) begin
                    n_to_tail = 1'b0; n_state = S_CH_W1;
                end else begin
                    n_state = S_TAKE;
                end
            end
            S_TAKE: begin
                rc_we = 1'b1; rc_wd = REF_W'(1);
                co_we = r_recol;
                n_res = r_p[PAGE_W-1:0];
                n_state = S_DONE;
            end
            S_CH_W1: begin
                if (r_to_tail) begin
                    pv_we = 1'b1; pv_wd = r_tail;
                    if (link_ok(r_tail)) begin
                        nx_we = 1'b1; nx_wa = r_tail[PAGE_W-1:0]; nx_wd = r_p;
                    end else begin
                        n_head = r_p;
                    end
                end else begin
                    nx_we = 1'b1; nx_wd = r_head;
                    if (link_ok(r_head)) begin
                        pv_we = 1'b1; pv_wa = r_head[PAGE_W-1:0]; pv_wd = r_p;
                    end else begin
                        n_tail = r_p;
                    end
                end
                n_state = S_CH_W2;
            end
            S_CH_W2: begin
                if (r_to_tail) begin
                    nx_we = 1'b1; n_tail = r_p;
                end else begin
                    pv_we = 1'b1; n_head = r_p;
                end
                n_free = r_free + LINK_W'(1);
                if (r_job.op == OP_REL) begin
                    n_state = S_DONE;
                end else begin
                    n_p = r_before; n_state = S_RC_NX;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UN_BCK) begin
            r_cur_prev <= NIL;
        end else if (r_state == S_UN_WALK) begin
            r_cur_prev <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;   r_p <= n_p;         r_before <= n_before;
        r_cur <= n_cur;   r_hnext <= n_hnext; r_b <= n_b;
        r_cnt <= n_cnt;   r_done <= n_done;   r_recol <= n_recol;
        r_to_tail <= n_to_tail; r_res <= n_res; r_status <= n_status;
        if (r_state == S_DONE && w_out_free) begin
            r_out.status      <= r_status;
            r_out.result_page <= 10'(r_res);
            r_out.recolored   <= r_recol;
            r_out.reclaimed   <= r_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_head      <= '0;
            r_tail      <= LINK_W'(NUM_PAGES - 1);
            r_free      <= LINK_W'(NUM_PAGES);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_free  <= n_free;
            if (r_state == S_CLEAR) begin
                r_idx <= r_idx + CLR_W'(1);
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.head = r_head;
    assign o_stat.tail = r_tail;
    assign o_stat.free = r_free;

endmodule

`default_nettype wire

// ----- src/colored_page_free_list.sv -----
// Colored page free list with reference counts and a hashed page cache.
// Top level: configuration register, front end queue and back end sequencer.
// Depends on cpfl_pkg, cpfl_front and cpfl_back.
//
// Requests arrive on the input channel (i_in_valid, o_in_stall, i_in_item);
// one transfer carries one request. Every request yields exactly one result
// on the output channel (o_out_valid, i_out_stall, o_out_item), in order.
// The user must write the high-water mark (i_cfg_we/i_cfg_wdata) while idle.
//
// The front end classifies each request and holds up to two of them, so the
// input side keeps taking transfers while the back end works or while a
// finished result waits in the output register. The back end handles one
// request at a time over memories with one read and one write port each and
// registered reads: an allocate steps through the free pages passed in the
// color search, a lookup through the hash chain entries, and each page
// unlinked from its hash chain through the entries of that chain. Reclaim
// handles its moved pages one after another.
//
// After reset a clearing pass rebuilds the free list and empties the
// buckets; requests are queued but not handled until it ends.
// A stalled receiver holds the result in the output register, and the back
// end waits in its final step until that register is free.
`default_nettype none

module colored_page_free_list import cpfl_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire t_in_item        i_in_item,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output t_out_item            o_out_item,
    input  wire logic            i_cfg_we,
    input  wire logic [HW_W-1:0] i_cfg_wdata
);

    logic [HW_W-1:0] r_high_water;
    logic            w_job_valid;
    logic            w_job_pop;
    t_job            w_job;
    t_stat           w_stat;

    // The high-water mark is the one configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_water <= HW_RESET;
        end else if (i_cfg_we) begin
            r_high_water <= i_cfg_wdata;
        end
    end

    cpfl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    cpfl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_job_valid),
        .i_job        (w_job),
        .o_job_pop    (w_job_pop),
        .i_high_water (r_high_water),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item),
        .o_stat       (w_stat)
    );

`ifndef NO_ASSERTIONS
    // Between requests the list is empty exactly when the free count is zero.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.idle |-> ((w_stat.head == NIL) == (w_stat.free == '0)))
        else $error("free list head disagrees with free count");

    // Between requests the head and tail are both null or both valid.
    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.idle |-> ((w_stat.head == NIL) == (w_stat.tail == NIL)))
        else $error("free list head and tail disagree");

    // The free count never exceeds the number of pages.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.free <= LINK_W'(NUM_PAGES))
        else $error("free count out of range");
`endif

endmodule

`default_nettype wire
